### rtl/core/sbas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbas_pkg: shared types and constants of the slider-block avalanche block
// Holds site count, command codes, register indexes, payload structs and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sbas_pkg;

    localparam int SITES        = 256;
    localparam int MAX_RANGE    = 64;
    localparam int IDX_W        = $clog2(SITES);
    localparam logic [19:0] FAIL_COUNT_MAX = 20'hFFFFF;
    localparam logic [31:0] LFSR_MASK      = 32'h80200003;

    // command codes
    localparam logic [1:0] FUNC_FILL  = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // register indexes
    localparam logic [2:0] REG_RESIDUAL  = 3'd0;
    localparam logic [2:0] REG_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_DRIVE     = 3'd2;
    localparam logic [2:0] REG_NOISE     = 3'd3;
    localparam logic [2:0] REG_SHARE     = 3'd4;
    localparam logic [2:0] REG_RANGE     = 3'd5;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] site_index;
    } t_in_word;

    typedef struct packed {
        logic [19:0] fail_count;
        logic [31:0] site_fails;
    } t_out_word;

    typedef struct packed {
        logic [15:0] residual_stress;
        logic [15:0] threshold_stress;
        logic [15:0] drive_step;
        logic [15:0] noise_amplitude;
        logic [15:0] neighbour_share;
        logic [6:0]  transfer_range;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;   // read stress and counter at addr
        logic             wr_fill;   // write noisy residual at addr
        logic             wr_drive;  // write stress + drive
        logic             wr_share;  // write stress + share
        logic             wr_fail;   // write noisy residual, bump counter
        logic [IDX_W-1:0] wr_addr;
        logic             cnt_clr;   // clear stress and counter at addr (reset sweep)
        logic             fails_clr;
        logic             out_tick;
        logic             out_query;
        logic             out_zero;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic over;        // read stress above threshold
        logic fails_full;  // tick fail count saturated
    } t_dp_sts;

endpackage

### rtl/core/slider_block_avalanche_sim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slider_block_avalanche_sim: 1D slider-block avalanche chain
// Channel  | handshake                | word
// command  | start / busy             | i_in (func, site_index)
// result   | o_valid (strobe)         | o_result (fail_count, site_fails)
// config   | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
// Fill writes all 256 sites, one a cycle, and strobes in the next cycle; a
// query strobes after the query state and the done register. A tick adds
// the drive step to every site, then scans; a failing site takes a noisy
// residual and shares stress with in-chain neighbours within the transfer
// range; passes repeat until one is quiet or the tick fail count saturates.
// After reset a pass over all 256 sites clears stress and fail counters with
// busy high. The result is shown one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module slider_block_avalanche_sim (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sbas_pkg::t_in_word  i_in,
    output logic                o_valid,
    output sbas_pkg::t_out_word o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    sbas_pkg::t_cfg    r_cfg;
    sbas_pkg::t_dp_cmd w_cmd;
    sbas_pkg::t_dp_sts w_sts;
    logic              w_done;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.residual_stress  <= 16'd4096;
            r_cfg.threshold_stress <= 16'd8192;
            r_cfg.drive_step       <= 16'd41;
            r_cfg.noise_amplitude  <= 16'd1024;
            r_cfg.neighbour_share  <= 16'd63;
            r_cfg.transfer_range   <= 7'd32;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sbas_pkg::REG_RESIDUAL:  r_cfg.residual_stress  <= i_cfg_data;
                sbas_pkg::REG_THRESHOLD: r_cfg.threshold_stress <= i_cfg_data;
                sbas_pkg::REG_DRIVE:     r_cfg.drive_step       <= i_cfg_data;
                sbas_pkg::REG_NOISE:     r_cfg.noise_amplitude  <= i_cfg_data;
                sbas_pkg::REG_SHARE:     r_cfg.neighbour_share  <= i_cfg_data;
                sbas_pkg::REG_RANGE:     r_cfg.transfer_range   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    sbas_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_in   (i_in),
        .i_range(r_cfg.transfer_range),
        .i_sts  (w_sts),
        .i_done (w_done),
        .o_cmd  (w_cmd),
        .o_busy (busy)
    );

    sbas_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_done  (w_done),
        .o_result(o_result)
    );

    assign o_valid = w_done;
endmodule

### rtl/core/sbas_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbas_ram: generic simple dual-port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module sbas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/sbas_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbas_datapath: site stores, noise source and arithmetic
// Stress and counter memories, Galois LFSR, noisy residual, saturating adds,
// tick fail count and the result register.
// ----------------------------------------------------------------------------
module sbas_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbas_pkg::t_cfg      i_cfg,
    input  sbas_pkg::t_dp_cmd   i_cmd,
    output sbas_pkg::t_dp_sts   o_sts,
    output logic                o_done,
    output sbas_pkg::t_out_word o_result
);
    logic [15:0] w_stress_rd;
    logic [31:0] w_cnt_rd;
    logic [15:0] w_stress_wd;
    logic [31:0] w_cnt_wd;
    logic        w_stress_we;
    logic        w_cnt_we;
    logic [31:0] r_lfsr;
    logic [31:0] n_lfsr;
    logic [19:0] r_fails;
    logic        r_done;
    sbas_pkg::t_out_word r_result;
    logic signed [13:0] w_u;
    logic signed [30:0] w_prod;
    logic signed [18:0] w_noise;
    logic signed [19:0] w_val;
    logic [15:0] w_noisy;
    logic [16:0] w_add_sum;
    logic [15:0] w_add_sat;
    logic        w_draw;

    // advance the LFSR one step
    always_comb begin
        n_lfsr = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? sbas_pkg::LFSR_MASK : 32'd0);
    end

    // noisy residual: floor(amp*u/4096) by arithmetic shift, then clamp
    always_comb begin
        w_u     = $signed({1'b0, n_lfsr[12:0]}) - 14'sd4096;
        w_prod  = $signed({1'b0, i_cfg.noise_amplitude}) * w_u;
        w_noise = w_prod[30:12];
        w_val   = $signed({4'd0, i_cfg.residual_stress}) + 20'(w_noise);
        if (w_val < 0) begin
            w_noisy = 16'd0;
        end else if (w_val > 20'sd65535) begin
            w_noisy = 16'hFFFF;
        end else begin
            w_noisy = w_val[15:0];
        end
    end

    // saturating add of drive step or share
    always_comb begin
        w_add_sum = {1'b0, w_stress_rd}
                  + {1'b0, i_cmd.wr_drive ? i_cfg.drive_step : i_cfg.neighbour_share};
        w_add_sat = w_add_sum[16] ? 16'hFFFF : w_add_sum[15:0];
    end

    assign w_draw      = i_cmd.wr_fill | i_cmd.wr_fail;
    assign w_stress_we = w_draw | i_cmd.wr_drive | i_cmd.wr_share | i_cmd.cnt_clr;
    assign w_stress_wd = i_cmd.cnt_clr ? 16'd0 : (w_draw ? w_noisy : w_add_sat);
    assign w_cnt_we    = i_cmd.wr_fail | i_cmd.cnt_clr;
    assign w_cnt_wd    = i_cmd.cnt_clr ? 32'd0
                       : (w_cnt_rd == 32'hFFFFFFFF ? w_cnt_rd : w_cnt_rd + 32'd1);

    sbas_ram #(.WIDTH(16), .DEPTH(sbas_pkg::SITES)) u_stress (
        .i_clk  (i_clk),
        .i_we   (w_stress_we),
        .i_waddr(i_cmd.wr_addr),
        .i_wdata(w_stress_wd),
        .i_raddr(i_cmd.rd_addr),
        .o_rdata(w_stress_rd)
    );

    sbas_ram #(.WIDTH(32), .DEPTH(sbas_pkg::SITES)) u_count (
        .i_clk  (i_clk),
        .i_we   (w_cnt_we),
        .i_waddr(i_cmd.wr_addr),
        .i_wdata(w_cnt_wd),
        .i_raddr(i_cmd.rd_addr),
        .o_rdata(w_cnt_rd)
    );

    // LFSR, tick fail count and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr  <= 32'd1;
            r_fails <= 20'd0;
            r_done  <= 1'b0;
        end else begin
            if (w_draw) begin
                r_lfsr <= n_lfsr;
            end
            if (i_cmd.fails_clr) begin
                r_fails <= 20'd0;
            end else if (i_cmd.wr_fail) begin
                r_fails <= r_fails + 20'd1;
            end
            r_done <= i_cmd.out_tick | i_cmd.out_query | i_cmd.out_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.fail_count <= i_cmd.out_tick ? r_fails : 20'd0;
        r_result.site_fails <= i_cmd.out_query ? w_cnt_rd : 32'd0;
    end

    assign o_sts.over       = w_stress_rd > i_cfg.threshold_stress;
    assign o_sts.fails_full = r_fails == sbas_pkg::FAIL_COUNT_MAX;
    assign o_done   = r_done;
    assign o_result = r_result;

    // a failure never lands while the count is saturated
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_fail |-> r_fails != sbas_pkg::FAIL_COUNT_MAX)
        else $error("fail counted past saturation");
    // only one kind of stress write at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.wr_fill, i_cmd.wr_drive, i_cmd.wr_share, i_cmd.wr_fail}))
        else $error("conflicting stress writes");
    // the LFSR never locks at zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_lfsr != 32'd0)
        else $error("LFSR reached zero");
endmodule

### rtl/core/sbas_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbas_ctrl: command sequencer
// Clears the site memories after reset, then runs fill, drive tick with
// avalanche scans, and query over the site memories one access per cycle.
// ----------------------------------------------------------------------------
module sbas_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  sbas_pkg::t_in_word i_in,
    input  logic [6:0]         i_range,
    input  sbas_pkg::t_dp_sts  i_sts,
    input  logic               i_done,
    output sbas_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);
    localparam int IW = sbas_pkg::IDX_W;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_FILL   = 11'b00000000100,
        S_DRIVE  = 11'b00000001000,
        S_DRWR   = 11'b00000010000,
        S_SCAN   = 11'b00000100000,
        S_TEST   = 11'b00001000000,
        S_SHRD   = 11'b00010000000,
        S_SHWR   = 11'b00100000000,
        S_QUERY  = 11'b01000000000,
        S_WAIT   = 11'b10000000000
    } t_state;

    t_state       r_state, n_state;
    logic [IW:0]  r_idx, n_idx;     // current site
    logic [IW:0]  r_nb, n_nb;       // neighbour position being updated
    logic [7:0]   r_m, n_m;         // neighbour distance, 1..range while sharing
    logic         r_side, n_side;   // 0 right, 1 left
    logic         r_again, n_again;
    logic [7:0]   w_range;
    logic [IW+1:0] w_pos;

    assign w_range = (i_range > 7'(sbas_pkg::MAX_RANGE)) ?
                     8'(sbas_pkg::MAX_RANGE) : {1'b0, i_range};

    // neighbour position for distance m on the chosen side
    function automatic logic [IW+1:0] nb_pos(input logic [IW:0] i, input logic [7:0] m,
                                             input logic side);
        logic [IW+1:0] p;
        begin
            p = side ? ({1'b0, i} - (IW+2)'(m)) : ({1'b0, i} + (IW+2)'(m));
            return p;
        end
    endfunction

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_nb    = r_nb;
        n_m     = r_m;
        n_side  = r_side;
        n_again = r_again;
        o_cmd   = '0;
        o_cmd.rd_addr = r_idx[IW-1:0];
        o_cmd.wr_addr = r_idx[IW-1:0];
        w_pos   = nb_pos(r_idx, r_m, r_side);
        case (r_state)
            S_CLEAR: begin
                o_cmd.cnt_clr = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == (IW+1)'(sbas_pkg::SITES - 1)) begin
                    n_state = S_IDLE;
                    n_idx = '0;
                end
            end
            S_IDLE: begin
                n_idx = '0;
                if (i_start) begin
                    case (i_in.func)
                        sbas_pkg::FUNC_FILL: n_state = S_FILL;
                        sbas_pkg::FUNC_TICK: begin
                            n_state = S_DRIVE;
                            o_cmd.fails_clr = 1'b1;
                        end
                        sbas_pkg::FUNC_QUERY: begin
                            // read the queried counter on the accepting edge
                            o_cmd.rd_addr = i_in.site_index[IW-1:0];
                            n_idx = {1'b0, i_in.site_index[IW-1:0]};
                            n_state = S_QUERY;
                        end
                        default: begin
                            o_cmd.out_zero = 1'b1;
                            n_state = S_WAIT;
                        end
                    endcase
                end
            end
            S_FILL: begin
                o_cmd.wr_fill = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == (IW+1)'(sbas_pkg::SITES - 1)) begin
                    o_cmd.out_zero = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_DRIVE: begin
                n_state = S_DRWR;
            end
            S_DRWR: begin
                o_cmd.wr_drive = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == (IW+1)'(sbas_pkg::SITES - 1)) begin
                    n_idx = '0;
                    n_again = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DRIVE;
                end
            end
            S_SCAN: begin
                n_state = S_TEST;
            end
            S_TEST: begin
                if (i_sts.over) begin
                    o_cmd.wr_fail = 1'b1;
                    n_again = 1'b1;
                    n_m = 8'd1;
                    n_side = 1'b0;
                    n_state = S_SHRD;
                end else begin
                    n_state = S_SHRD;
                    n_m = 8'd0;
                end
            end
            S_SHRD: begin
                // walk neighbours, skipping those off the chain
                if (r_m == 8'd0 || r_m > w_range) begin
                    if (r_side == 1'b0 && r_m != 8'd0) begin
                        n_side = 1'b1;
                        n_m = 8'd1;
                    end else if (i_sts.fails_full) begin
                        // stop a runaway avalanche once the last share is out
                        o_cmd.out_tick = 1'b1;
                        n_state = S_WAIT;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_side = 1'b0;
                        n_state = S_SCAN;
                        if (r_idx == (IW+1)'(sbas_pkg::SITES - 1)) begin
                            n_idx = '0;
                            n_again = 1'b0;
                            if (!r_again) begin
                                o_cmd.out_tick = 1'b1;
                                n_state = S_WAIT;
                            end
                        end
                    end
                end else if (w_pos[IW+1] || w_pos[IW]) begin
                    n_m = r_m + 8'd1;
                end else begin
                    o_cmd.rd_addr = w_pos[IW-1:0];
                    n_nb = w_pos[IW:0];
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                o_cmd.wr_share = 1'b1;
                o_cmd.wr_addr = r_nb[IW-1:0];
                n_m = r_m + 8'd1;
                n_state = S_SHRD;
            end
            S_QUERY: begin
                o_cmd.out_query = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                n_idx = '0;
                if (i_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_nb    <= '0;
            r_m     <= '0;
            r_side  <= 1'b0;
            r_again <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_nb    <= n_nb;
            r_m     <= n_m;
            r_side  <= n_side;
            r_again <= n_again;
        end
    end

    assign o_busy = r_state != S_IDLE;

    // start is only taken from idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> r_state != S_IDLE)
        else $error("start not taken");
    // a result strobe is always followed by a return to idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && i_done) |=> r_state == S_IDLE)
        else $error("wait did not end");
    // a share write always follows its read
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHWR |-> $past(r_state) == S_SHRD)
        else $error("share write without read");
endmodule
